// File: sv/tid_pkg.sv
package tid_pkg;

    // Countdown periods in input cycles
    localparam int CD_W = 12;
    localparam logic [CD_W-1:0] DIV_PERIOD     = 12'd256;
    localparam logic [CD_W-1:0] TIMER_PERIOD_0 = 12'd1024;
    localparam logic [CD_W-1:0] TIMER_PERIOD_1 = 12'd16;
    localparam logic [CD_W-1:0] TIMER_PERIOD_2 = 12'd64;
    localparam logic [CD_W-1:0] TIMER_PERIOD_3 = 12'd256;

    localparam int NUM_SRC = 5;
    localparam int SRC_W   = 3;

    // Interrupt source of the timer overflow
    localparam logic [SRC_W-1:0] SRC_TIMER = 3'd2;

    localparam logic [7:0] CNT_MAX  = 8'hff;
    localparam logic [7:0] VEC_BASE = 8'h40;

    // Control register fields
    localparam int CTRL_EN_BIT = 2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CONTROL = 2'd0;
    localparam logic [1:0] REG_MODULO  = 2'd1;
    localparam logic [1:0] REG_ENABLE  = 2'd2;

    // Timer unit results for one beat
    typedef struct packed {
        logic       irq;
        logic [7:0] div;
        logic [7:0] cnt;
    } t_tmr;

    // Dispatch results for one beat
    typedef struct packed {
        logic               take;
        logic [7:0]         vec;
        logic [15:0]        ret;
        logic [NUM_SRC-1:0] flags;
        logic               me;
    } t_disp;

    function automatic logic [CD_W-1:0] timer_period(input logic [1:0] sel);
        logic [CD_W-1:0] p;
        case (sel)
            2'd0:    p = TIMER_PERIOD_0;
            2'd1:    p = TIMER_PERIOD_1;
            2'd2:    p = TIMER_PERIOD_2;
            2'd3:    p = TIMER_PERIOD_3;
            default: p = TIMER_PERIOD_0;
        endcase
        return p;
    endfunction

endpackage

// File: sv/tid_timer.sv
module tid_timer
    import tid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [5:0] i_cycles,
    input  logic [2:0] i_control,
    input  logic [7:0] i_modulo,
    output t_tmr       o_tmr
);

    logic [CD_W-1:0] r_div_cd, n_div_cd;
    logic [7:0]      r_div_cnt, n_div_cnt;
    logic [CD_W-1:0] r_tmr_cd, n_tmr_cd;
    logic [7:0]      r_tmr_cnt, n_tmr_cnt;
    logic [CD_W:0]   div_diff;
    logic [CD_W:0]   tmr_diff;
    logic            div_exp;
    logic            tmr_exp;
    logic            irq;

    // Subtract the beat's cycles; zero or below means expiry
    assign div_diff = {1'b0, r_div_cd} - {{(CD_W-5){1'b0}}, i_cycles};
    assign tmr_diff = {1'b0, r_tmr_cd} - {{(CD_W-5){1'b0}}, i_cycles};
    assign div_exp  = div_diff[CD_W] || (div_diff == '0);
    assign tmr_exp  = tmr_diff[CD_W] || (tmr_diff == '0);

    // Advance the divider
    always_comb begin
        if (div_exp) begin
            n_div_cd  = DIV_PERIOD;
            n_div_cnt = r_div_cnt + 8'd1;
        end else begin
            n_div_cd  = div_diff[CD_W-1:0];
            n_div_cnt = r_div_cnt;
        end
    end

    // When enabled, advance the timer counter, reload from modulo on overflow
    always_comb begin
        n_tmr_cd  = r_tmr_cd;
        n_tmr_cnt = r_tmr_cnt;
        irq       = 1'b0;
        if (i_control[CTRL_EN_BIT]) begin
            if (tmr_exp) begin
                n_tmr_cd = timer_period(i_control[1:0]);
                if (r_tmr_cnt == CNT_MAX) begin
                    n_tmr_cnt = i_modulo;
                    irq       = 1'b1;
                end else begin
                    n_tmr_cnt = r_tmr_cnt + 8'd1;
                end
            end else begin
                n_tmr_cd = tmr_diff[CD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cd  <= DIV_PERIOD;
            r_div_cnt <= '0;
            r_tmr_cd  <= TIMER_PERIOD_0;
            r_tmr_cnt <= '0;
        end else if (i_accept) begin
            r_div_cd  <= n_div_cd;
            r_div_cnt <= n_div_cnt;
            r_tmr_cd  <= n_tmr_cd;
            r_tmr_cnt <= n_tmr_cnt;
        end
    end

    assign o_tmr.irq = irq;
    assign o_tmr.div = n_div_cnt;
    assign o_tmr.cnt = n_tmr_cnt;

endmodule

// File: sv/tid_dispatch.sv
module tid_dispatch
    import tid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_disable,
    input  logic               i_enable,
    input  logic [NUM_SRC-1:0] i_ext,
    input  logic               i_halted,
    input  logic [15:0]        i_pc,
    input  logic               i_timer_irq,
    input  logic [NUM_SRC-1:0] i_mask,
    output t_disp              o_disp
);

    logic [NUM_SRC-1:0] r_pend, n_pend;
    logic               r_me, n_me;
    logic               me_pre;
    logic [NUM_SRC-1:0] pend_pre;
    logic [NUM_SRC-1:0] ready;
    logic [SRC_W-1:0]   src;
    logic               take;

    // Apply clear, then set, of the master enable
    always_comb begin
        if (i_enable) begin
            me_pre = 1'b1;
        end else if (i_disable) begin
            me_pre = 1'b0;
        end else begin
            me_pre = r_me;
        end
    end

    // Merge new requests
    always_comb begin
        pend_pre = r_pend | i_ext;
        if (i_timer_irq) begin
            pend_pre[SRC_TIMER] = 1'b1;
        end
    end

    assign ready = pend_pre & i_mask;
    assign take  = me_pre && (ready != '0);

    // Pick the lowest ready source
    always_comb begin
        src = '0;
        for (int k = NUM_SRC - 1; k >= 0; k--) begin
            if (ready[k]) begin
                src = SRC_W'(k);
            end
        end
    end

    // Clear the serviced request and the master enable
    always_comb begin
        n_pend = pend_pre;
        n_me   = me_pre;
        if (take) begin
            n_pend[src] = 1'b0;
            n_me        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_me   <= 1'b0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_me   <= n_me;
        end
    end

    assign o_disp.take  = take;
    assign o_disp.vec   = take ? (VEC_BASE + {2'b00, src, 3'b000}) : 8'd0;
    assign o_disp.ret   = take ? (i_pc + {15'd0, i_halted}) : 16'd0;
    assign o_disp.flags = n_pend;
    assign o_disp.me    = n_me;

endmodule

// File: sv/timer_and_interrupt_dispatch.sv
// Timer and interrupt dispatch, one input beat per executed instruction.
//
// Slave stream (s_axis_*): one beat per instruction with its cycle count,
// master enable clear/set, external request bits, halt flag and program
// counter. Master stream (m_axis_*): one result beat per input beat with
// the dispatch decision, vector, return address, divider and timer values,
// pending flags and master enable after the step.
// APB port: timer_control at 0x0, timer_modulo at 0x4, interrupt_enable
// at 0x8; writes elsewhere are dropped; pready is tied high.
//
// The result beat is valid in the cycle after the input beat is accepted.
// Throughput is one beat per cycle while results are taken; the single
// state update per beat (countdowns, counters, pending flags) sits between
// the input handshake and the result register.
// When the receiver stalls, the result register holds its beat and the
// input is refused until it is taken; a beat is accepted in the same cycle
// the held result leaves.
// Synchronous active-low reset restores the countdowns to their periods,
// clears counters, flags, master enable and registers, and empties the
// result register.
module timer_and_interrupt_dispatch
    import tid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] elapsed_cycles, [6] disable_master, [7] enable_master,
    // [12:8] external_requests, [13] cpu_halted, [29:14] program_counter
    input  logic [31:0] s_axis_tdata,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] take_interrupt, [8:1] vector_address, [24:9] return_address,
    // [32:25] divider_value, [40:33] counter_value, [45:41] request_flags,
    // [46] master_enable
    output logic [47:0] m_axis_tdata
);

    logic [2:0]         r_control;
    logic [7:0]         r_modulo;
    logic [NUM_SRC-1:0] r_mask;
    logic               r_out_valid;
    logic [46:0]        r_out_data;
    logic               cfg_wr;
    logic               accept;
    t_tmr               tmr;
    t_disp              disp;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_modulo  <= '0;
            r_mask    <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_CONTROL: r_control <= pwdata[2:0];
                REG_MODULO:  r_modulo  <= pwdata[7:0];
                REG_ENABLE:  r_mask    <= pwdata[NUM_SRC-1:0];
                default:     ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            REG_CONTROL: prdata = {29'd0, r_control};
            REG_MODULO:  prdata = {24'd0, r_modulo};
            REG_ENABLE:  prdata = {{(32-NUM_SRC){1'b0}}, r_mask};
            default:     prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tid_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_cycles  (s_axis_tdata[5:0]),
        .i_control (r_control),
        .i_modulo  (r_modulo),
        .o_tmr     (tmr)
    );

    tid_dispatch u_dispatch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_disable   (s_axis_tdata[6]),
        .i_enable    (s_axis_tdata[7]),
        .i_ext       (s_axis_tdata[12:8]),
        .i_halted    (s_axis_tdata[13]),
        .i_pc        (s_axis_tdata[29:14]),
        .i_timer_irq (tmr.irq),
        .i_mask      (r_mask),
        .o_disp      (disp)
    );

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {disp.me, disp.flags, tmr.cnt, tmr.div,
                           disp.ret, disp.vec, disp.take};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_data};

`ifndef ASSERT_OFF
    // A dispatch always leaves the master enable off
    a_take_clears_me: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[46])
        else $error("master enable set after dispatch");

    // Vector is one of the five handlers on dispatch; vector and return address are zero otherwise
    a_vector_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] ?
            (m_axis_tdata[8:1] == 8'h40 || m_axis_tdata[8:1] == 8'h48 ||
             m_axis_tdata[8:1] == 8'h50 || m_axis_tdata[8:1] == 8'h58 ||
             m_axis_tdata[8:1] == 8'h60) : (m_axis_tdata[24:1] == 24'd0)))
        else $error("bad vector or address");

    // An accepted beat always produces a result in the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted beat lost");
`endif

endmodule
